@@ sv/text_console_cursor_engine_top_macros.svh @@
// ----------------------------------------------------------------------------
// Text console cursor engine - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcce assertion failed");

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcce assertion failed");

`endif

@@ sv/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - package
// Geometry, character codes, action codes and controller/datapath types.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SWEEP_W = $clog2(CELLS + 1);
  localparam int CELL_W  = 16;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int CADDR_W  = 11;
  localparam int POS_W    = 11;
  localparam int ATTR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT       = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_INIT,
    MEM_CLEAR,
    MEM_COPY,
    MEM_BLANK,
    MEM_UPDATE
  } mem_op_e;

  typedef enum logic [1:0] {
    SW_ZERO,
    SW_COPY,
    SW_BLANK
  } sweep_sel_e;

  typedef struct packed {
    logic       latch;
    logic       sweep_ld;
    sweep_sel_e sweep_sel;
    logic       sweep_inc;
    mem_op_e    mem_op;
    logic       mark_scroll;
    logic       cursor_home;
    logic       cursor_commit;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic need_scroll;
    logic sweep_last;
    logic sweep_end;
    logic out_free;
  } status_t;

endpackage

@@ sv/tcce_in_if.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - action channel
// Valid/ready channel carrying one console action per item.
// ----------------------------------------------------------------------------
interface tcce_in_if;
  import tcce_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]  char_code;
  logic [CADDR_W-1:0] cell_address;

  modport source (output valid, output action, output char_code, output cell_address,
                  input ready);
  modport sink   (input valid, input action, input char_code, input cell_address,
                  output ready);
endinterface

@@ sv/tcce_out_if.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - result channel
// Valid/ready channel carrying one result item per action.
// ----------------------------------------------------------------------------
interface tcce_out_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] read_data;
  logic              scrolled;

  modport source (output valid, output cursor_position, output read_data, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor_position, input read_data, input scrolled,
                  output ready);
endinterface

@@ sv/tcce_ram.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tcce_datapath.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - datapath
// Cursor, attribute, sweep counter, screen store and result register.
// ----------------------------------------------------------------------------
module tcce_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcce_pkg::cmd_t               cmd_i,
  output tcce_pkg::status_t            status_o,
  input  logic                         attr_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]  attr_i,
  input  logic [tcce_pkg::ACTION_W-1:0] action_i,
  input  logic [tcce_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcce_pkg::CADDR_W-1:0] cell_address_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [tcce_pkg::POS_W-1:0]   cursor_position_o,
  output logic [tcce_pkg::CELL_W-1:0]  read_data_o,
  output logic                         scrolled_o
);
  import tcce_pkg::*;

  localparam logic [COL_W:0] COLS_X   = (COL_W+1)'(COLUMNS);
  localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(TAB_STEP - 1));

  logic [ATTR_W-1:0]  attr_q;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [SWEEP_W-1:0] sweep_q, sweep_d;
  action_e            act_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [CADDR_W-1:0] addr_q;
  logic               scr_q;
  logic               out_valid_q;
  logic [POS_W-1:0]   pos_q;
  logic [CELL_W-1:0]  rdat_q;
  logic               oscr_q;

  logic               last_row, col_last, is_cr, is_lf, is_tab, printable, tab_wrap;
  logic [ROW_W-1:0]   row_adv, row_n, wr_row;
  logic [COL_W-1:0]   col_n, wr_col;
  logic [COL_W:0]     tab_col;
  logic               upd_we;
  logic [CELL_W-1:0]  upd_data;
  logic [ADDR_W-1:0]  upd_idx;
  logic               addr_ok;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SWEEP_W-1:0] copy_dst;
  logic [CELL_W-1:0]  blank;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  assign last_row  = (row_q == ROW_W'(ROWS - 1));
  assign col_last  = (col_q == COL_W'(COLUMNS - 1));
  assign row_adv   = last_row ? row_q : row_q + ROW_W'(1);
  assign is_cr     = (ch_q == CH_CR);
  assign is_lf     = (ch_q == CH_LF);
  assign is_tab    = (ch_q == CH_TAB);
  assign printable = !(is_cr || is_lf || is_tab);
  assign tab_col   = ((COL_W+1)'(col_q) + (COL_W+1)'(TAB_STEP)) & TAB_MASK;
  assign tab_wrap  = (tab_col >= COLS_X);
  assign blank     = {attr_q, CH_SPACE};

  always_comb begin
    row_n    = row_q;
    col_n    = col_q;
    wr_row   = row_q;
    wr_col   = col_q;
    upd_we   = 1'b0;
    upd_data = blank;
    case (act_q)
      ACT_PUT: begin
        if (is_cr) begin
          col_n = '0;
        end else if (is_lf) begin
          row_n = row_adv;
          col_n = '0;
        end else if (is_tab) begin
          if (tab_wrap) begin
            row_n = row_adv;
            col_n = '0;
          end else begin
            col_n = tab_col[COL_W-1:0];
          end
        end else begin
          upd_we   = 1'b1;
          upd_data = {attr_q, ch_q};
          if (col_last) begin
            wr_row = row_adv;
            wr_col = '0;
            row_n  = row_adv;
            col_n  = COL_W'(1);
          end else begin
            col_n = col_q + COL_W'(1);
          end
        end
      end
      ACT_BACKSPACE: begin
        if (row_q != '0 || col_q != '0) begin
          upd_we = 1'b1;
          if (col_q != '0) begin
            col_n = col_q - COL_W'(1);
          end else begin
            row_n = row_q - ROW_W'(1);
            col_n = COL_W'(COLUMNS - 1);
          end
          wr_row = row_n;
          wr_col = col_n;
        end
      end
      default: ;
    endcase
  end

  assign upd_idx  = ADDR_W'(32'(wr_row) * COLUMNS + 32'(wr_col));
  assign addr_ok  = (32'(addr_q) < CELLS);
  assign rd_addr  = addr_ok ? ADDR_W'(addr_q) : '0;
  assign copy_dst = sweep_q - SWEEP_W'(COLUMNS + 1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q[ADDR_W-1:0];
    ram_wdata = blank;
    ram_raddr = rd_addr;
    case (cmd_i.mem_op)
      MEM_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_RESET;
      end
      MEM_CLEAR, MEM_BLANK: begin
        ram_we = 1'b1;
      end
      MEM_COPY: begin
        ram_we    = (sweep_q != SWEEP_W'(COLUMNS));
        ram_waddr = copy_dst[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (sweep_q < SWEEP_W'(CELLS)) begin
          ram_raddr = sweep_q[ADDR_W-1:0];
        end
      end
      MEM_UPDATE: begin
        ram_we    = upd_we;
        ram_waddr = upd_idx;
        ram_wdata = upd_data;
      end
      default: ;
    endcase
  end

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sweep_d = sweep_q;
    if (cmd_i.sweep_ld) begin
      unique case (cmd_i.sweep_sel)
        SW_ZERO:  sweep_d = '0;
        SW_COPY:  sweep_d = SWEEP_W'(COLUMNS);
        SW_BLANK: sweep_d = SWEEP_W'(CELLS - COLUMNS);
        default:  sweep_d = '0;
      endcase
    end else if (cmd_i.sweep_inc) begin
      sweep_d = sweep_q + SWEEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      row_q       <= '0;
      col_q       <= '0;
      sweep_q     <= '0;
      scr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (attr_we_i) begin
        attr_q <= attr_i;
      end
      sweep_q <= sweep_d;
      if (cmd_i.cursor_home) begin
        row_q <= '0;
        col_q <= '0;
      end else if (cmd_i.cursor_commit) begin
        row_q <= row_n;
        col_q <= col_n;
      end
      if (cmd_i.latch) begin
        scr_q <= 1'b0;
      end else if (cmd_i.mark_scroll) begin
        scr_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_e'(action_i);
      ch_q   <= char_code_i;
      addr_q <= cell_address_i;
    end
    if (cmd_i.out_load) begin
      pos_q  <= POS_W'(32'(row_q) * COLUMNS + 32'(col_q));
      rdat_q <= (act_q == ACT_READ && addr_ok) ? ram_rdata : '0;
      oscr_q <= scr_q;
    end
  end

  assign status_o.is_clear    = (act_q == ACT_CLEAR);
  assign status_o.is_read     = (act_q == ACT_READ);
  assign status_o.need_scroll = (act_q == ACT_PUT) && last_row &&
                                (is_lf || (is_tab && tab_wrap) || (printable && col_last));
  assign status_o.sweep_last  = (sweep_q == SWEEP_W'(CELLS - 1));
  assign status_o.sweep_end   = (sweep_q == SWEEP_W'(CELLS));
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = pos_q;
  assign read_data_o       = rdat_q;
  assign scrolled_o        = oscr_q;

endmodule

@@ sv/tcce_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - controller
// Sequences reset fill, clear, scroll copy/blank, cell update and result.
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcce_pkg::status_t status_i,
  output tcce_pkg::cmd_t    cmd_o
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_COPY,
    S_BLANK,
    S_UPDATE,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mem_op    = MEM_IDLE;
    cmd_o.sweep_sel = SW_ZERO;
    unique case (state_q)
      S_INIT: begin
        cmd_o.mem_op    = MEM_INIT;
        cmd_o.sweep_inc = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_clear) begin
          cmd_o.sweep_ld  = 1'b1;
          cmd_o.sweep_sel = SW_ZERO;
          state_d         = S_CLEAR;
        end else if (status_i.is_read) begin
          state_d = S_DONE;
        end else if (status_i.need_scroll) begin
          cmd_o.sweep_ld    = 1'b1;
          cmd_o.sweep_sel   = SW_COPY;
          cmd_o.mark_scroll = 1'b1;
          state_d           = S_COPY;
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_CLEAR: begin
        cmd_o.mem_op    = MEM_CLEAR;
        cmd_o.sweep_inc = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.cursor_home = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_COPY: begin
        cmd_o.mem_op    = MEM_COPY;
        cmd_o.sweep_inc = 1'b1;
        if (status_i.sweep_end) begin
          cmd_o.sweep_ld  = 1'b1;
          cmd_o.sweep_sel = SW_BLANK;
          state_d         = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd_o.mem_op    = MEM_BLANK;
        cmd_o.sweep_inc = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.mem_op        = MEM_UPDATE;
        cmd_o.cursor_commit = 1'b1;
        state_d             = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ sv/text_console_cursor_engine_top.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine - top level
// Console action engine with cursor tracking and a character/attribute store.
// ----------------------------------------------------------------------------
// After reset the store is filled with blanks (0x0720) one cell a cycle, and
// no item is taken until the fill is done; attribute writes are taken
// throughout. An item is then handled one at a time, each ending with its
// result presented: a put, CR, LF, tab or backspace moves the cursor (a put
// or backspace also writes a cell), a cell read fetches a cell, a clear blanks
// every cell, and an item that scrolls first copies and blanks the store.
// The screen store has a single write port, which moves one cell per cycle. A
// finished result sits in an output register, so the next item is accepted
// while it waits.
`include "text_console_cursor_engine_top_macros.svh"

module text_console_cursor_engine_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        text_attribute_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0] text_attribute_i,
  tcce_in_if.sink                     in_i,
  tcce_out_if.source                  out_o
);
  import tcce_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcce_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .attr_we_i         (text_attribute_we_i),
    .attr_i            (text_attribute_i),
    .action_i          (in_i.action),
    .char_code_i       (in_i.char_code),
    .cell_address_i    (in_i.cell_address),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .cursor_position_o (out_o.cursor_position),
    .read_data_o       (out_o.read_data),
    .scrolled_o        (out_o.scrolled)
  );

  `TCCE_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `TCCE_ASSERT_NOW(a_pos_in_range, out_o.valid, (CELLS > 2048) || (32'(out_o.cursor_position) < CELLS))
  `TCCE_ASSERT_NOW(a_scroll_last_row, out_o.valid && out_o.scrolled, (CELLS > 2048) || (32'(out_o.cursor_position) >= CELLS - COLUMNS))
  `TCCE_ASSERT_NOW(a_one_cmd_source, cmd.latch, !cmd.out_load && !cmd.cursor_commit)

endmodule
